[sv/countdown_timer_with_alerts_macros.svh]
// Assertion helpers shared by the timer RTL.
`ifndef COUNTDOWN_TIMER_WITH_ALERTS_MACROS_SVH
`define COUNTDOWN_TIMER_WITH_ALERTS_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define CDTA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("timer check failed (same cycle)");

// Consequent checked in the cycle after the antecedent.
`define CDTA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("timer check failed (next cycle)");

`endif

[sv/cdta_pkg.sv]
package cdta_pkg;

   localparam int ALERT_REGS = 4;
   localparam int MASK_W     = 4;
   localparam int REM_W      = 26;
   localparam int SEC_W      = 17;
   localparam int TOTAL_W    = 16;
   localparam int ALERT_W    = 10;
   localparam int TIME_W     = 32;

   localparam logic [REM_W-1:0] MS_PER_SEC  = 26'd1000;
   localparam logic [REM_W:0]   ROUND_UP_MS = 27'd999;

   // floor(x / 1000) == (x * SEC_RECIP) >> SEC_SHIFT, exact for x < 2^27
   localparam logic [27:0] SEC_RECIP = 28'd137438954;
   localparam int          SEC_SHIFT = 37;
   localparam int          PROD_W    = 55;

   localparam logic [TOTAL_W-1:0] TOTAL_RESET = 16'd600;
   localparam logic [ALERT_REGS-1:0][ALERT_W-1:0] ALERT_RESET =
      {10'd3, 10'd10, 10'd20, 10'd30};
   localparam logic signed [SEC_W-1:0] NO_SECONDS = -17'sd1;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_START = 2'd1,
      OP_RESET = 2'd2,
      OP_SYNC  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      REG_TOTAL  = 3'd0,
      REG_ALERT0 = 3'd1,
      REG_ALERT1 = 3'd2,
      REG_ALERT2 = 3'd3,
      REG_ALERT3 = 3'd4
   } reg_index_type;

   // one event after the countdown stage, on its way to the alert stage
   typedef struct packed {
      op_type               kind;
      logic                 do_alert;
      logic [REM_W-1:0]     remaining;
      logic                 running;
      logic                 started;
      logic [TOTAL_W-1:0]   secs;
   } pipe_item_type;

   typedef struct packed {
      logic [MASK_W-1:0]        mask;
      logic signed [SEC_W-1:0]  seconds;
   } alert_result_type;

endpackage

[sv/countdown_timer_with_alerts.sv]
// Countdown timer with one-shot alerts, two-stage pipeline.
// An input transfer is registered in the pipe register, then in the result register.
// Throughput: one event per cycle while results are not stalled; the alert stage's
// constant-reciprocal multiply for ceiling seconds sets the cycle.
// Reset (synchronous): registers to defaults, 600 000 ms loaded, timer stopped,
// no alerts fired, pipeline empty. No clearing pass.
`include "countdown_timer_with_alerts_macros.svh"

module countdown_timer_with_alerts #(
   parameter int NUM_ALERTS = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   // event channel
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [1:0]                 req_op,
   input  logic [31:0]                req_now_ms,
   input  logic signed [16:0]         req_sync_seconds,
   // result channel
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [3:0]                 rsp_alert_mask,
   output logic [25:0]                rsp_remaining_ms,
   output logic signed [16:0]         rsp_alert_seconds,
   output logic                       rsp_is_running,
   output logic                       rsp_was_started,
   // register port
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [4:0]                 paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);
   import cdta_pkg::*;

   // alerts beyond the threshold registers do not exist
   localparam int ALERT_CNT = (NUM_ALERTS < ALERT_REGS) ? NUM_ALERTS : ALERT_REGS;

   // ---------------------------------------------------------------
   // Register file
   // ---------------------------------------------------------------
   logic [TOTAL_W-1:0]                  total_ff, total_in;
   logic [ALERT_REGS-1:0][ALERT_W-1:0]  thr_ff, thr_in;
   logic                                cfg_wr;
   logic                                cfg_wr_total;
   logic [2:0]                          cfg_idx;

   assign pready  = 1'b1;
   assign cfg_wr  = psel && penable && pwrite && pready;
   assign cfg_idx = paddr[4:2];

   always_comb begin
      total_in     = total_ff;
      thr_in       = thr_ff;
      cfg_wr_total = 1'b0;
      if (cfg_wr) begin
         case (cfg_idx)
            REG_TOTAL: begin
               total_in     = pwdata[TOTAL_W-1:0];
               cfg_wr_total = 1'b1;   // a total write also reloads and stops the countdown
            end
            REG_ALERT0: thr_in[0] = pwdata[ALERT_W-1:0];
            REG_ALERT1: thr_in[1] = pwdata[ALERT_W-1:0];
            REG_ALERT2: thr_in[2] = pwdata[ALERT_W-1:0];
            REG_ALERT3: thr_in[3] = pwdata[ALERT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (cfg_idx)
         REG_TOTAL:  prdata = 32'(total_ff);
         REG_ALERT0: prdata = 32'(thr_ff[0]);
         REG_ALERT1: prdata = 32'(thr_ff[1]);
         REG_ALERT2: prdata = 32'(thr_ff[2]);
         REG_ALERT3: prdata = 32'(thr_ff[3]);
         default:    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= TOTAL_RESET;
         thr_ff   <= ALERT_RESET;
      end else begin
         total_ff <= total_in;
         thr_ff   <= thr_in;
      end
   end

   // ---------------------------------------------------------------
   // Handshake: pipe register, then result register.
   // The pipe register takes a new event while a result is stalled only when
   // it is empty, so one event can be absorbed behind a held result.
   // ---------------------------------------------------------------
   logic          pipe_valid_ff, pipe_valid_in;
   pipe_item_type pipe_ff, pipe_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_load;
   logic          pipe_adv;
   logic          req_accept;

   assign rsp_load   = !rsp_valid_ff || !rsp_stall;
   assign pipe_adv   = pipe_valid_ff && rsp_load;
   assign req_stall  = pipe_valid_ff && !rsp_load;
   assign req_accept = req_valid && !req_stall;

   assign pipe_valid_in = req_accept || (pipe_valid_ff && !pipe_adv);
   assign rsp_valid_in  = rsp_load ? pipe_valid_ff : rsp_valid_ff;

   // ---------------------------------------------------------------
   // Countdown stage: time, tick base and run flags
   // ---------------------------------------------------------------
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [TIME_W-1:0]  last_tick_ff, last_tick_in;
   logic               running_ff, running_in;
   logic               started_ff, started_in;
   logic [TIME_W-1:0]  elapsed;
   logic [REM_W-1:0]   rem_after_tick;
   logic [REM_W-1:0]   reload_ms;
   logic [TOTAL_W-1:0] sync_secs;
   logic [REM_W-1:0]   sync_ms;
   op_type             op;

   assign op        = op_type'(req_op);
   // wrapped elapsed time since the last tick
   assign elapsed   = req_now_ms - last_tick_ff;
   assign rem_after_tick = (elapsed >= TIME_W'(rem_ff)) ? '0
                         : rem_ff - elapsed[REM_W-1:0];
   assign reload_ms = REM_W'(total_ff) * MS_PER_SEC;
   // negative targets clamp to zero
   assign sync_secs = req_sync_seconds[SEC_W-1] ? '0 : req_sync_seconds[TOTAL_W-1:0];
   assign sync_ms   = REM_W'(sync_secs) * MS_PER_SEC;

   always_comb begin
      rem_in       = rem_ff;
      last_tick_in = last_tick_ff;
      running_in   = running_ff;
      started_in   = started_ff;
      if (cfg_wr_total) begin
         rem_in       = REM_W'(total_in) * MS_PER_SEC;
         last_tick_in = '0;
         running_in   = 1'b0;
         started_in   = 1'b0;
      end else if (req_accept) begin
         case (op)
            OP_TICK: begin
               if (running_ff) begin
                  last_tick_in = req_now_ms;
                  rem_in       = rem_after_tick;
                  if (rem_after_tick == '0) begin
                     running_in = 1'b0;   // stops by itself at zero
                  end
               end
            end
            OP_START: begin
               if (!running_ff) begin
                  running_in   = 1'b1;
                  started_in   = 1'b1;
                  last_tick_in = req_now_ms;
               end
            end
            OP_RESET: begin
               rem_in       = reload_ms;
               last_tick_in = '0;
               running_in   = 1'b0;
               started_in   = 1'b0;
            end
            OP_SYNC: begin
               rem_in       = sync_ms;
               last_tick_in = req_now_ms;
               if (sync_secs == '0) begin
                  running_in = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      pipe_in.kind      = op;
      pipe_in.do_alert  = running_ff;   // a tick while stopped leaves alerts alone
      pipe_in.remaining = rem_in;
      pipe_in.running   = running_in;
      pipe_in.started   = started_in;
      pipe_in.secs      = sync_secs;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff        <= REM_W'(TOTAL_RESET) * MS_PER_SEC;
         last_tick_ff  <= '0;
         running_ff    <= 1'b0;
         started_ff    <= 1'b0;
         pipe_valid_ff <= 1'b0;
      end else begin
         rem_ff        <= rem_in;
         last_tick_ff  <= last_tick_in;
         running_ff    <= running_in;
         started_ff    <= started_in;
         pipe_valid_ff <= pipe_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         pipe_ff <= pipe_in;
      end
   end

   // ---------------------------------------------------------------
   // Alert stage: ceiling seconds and threshold crossings
   // ---------------------------------------------------------------
   alert_result_type alert_res;

   cdta_alert_unit #(
      .ALERT_CNT (ALERT_CNT)
   ) u_alert (
      .clock      (clock),
      .reset      (reset),
      .reload     (cfg_wr_total),
      .advance    (pipe_adv),
      .item       (pipe_ff),
      .thresholds (thr_ff),
      .result     (alert_res)
   );

   // ---------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------
   logic [MASK_W-1:0]       rsp_mask_ff;
   logic [REM_W-1:0]        rsp_rem_ff;
   logic signed [SEC_W-1:0] rsp_sec_ff;
   logic                    rsp_run_ff;
   logic                    rsp_start_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         rsp_mask_ff  <= alert_res.mask;
         rsp_rem_ff   <= pipe_ff.remaining;
         rsp_sec_ff   <= alert_res.seconds;
         rsp_run_ff   <= pipe_ff.running;
         rsp_start_ff <= pipe_ff.started;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_alert_mask    = rsp_mask_ff;
   assign rsp_remaining_ms  = rsp_rem_ff;
   assign rsp_alert_seconds = rsp_sec_ff;
   assign rsp_is_running    = rsp_run_ff;
   assign rsp_was_started   = rsp_start_ff;

   // ---------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------
   // a fired alert always comes with a real seconds value
   `CDTA_ASSERT_SAME(a_alert_has_seconds, clock, reset, rsp_valid_ff && |rsp_mask_ff, rsp_sec_ff >= 0)
   // running is only possible after a start
   `CDTA_ASSERT_SAME(a_run_needs_start, clock, reset, rsp_valid_ff && !rsp_start_ff, !rsp_run_ff)
   // remaining time moves only on a transfer or a total write
   `CDTA_ASSERT_NEXT(a_rem_holds, clock, reset, !req_accept && !cfg_wr_total, $stable(rem_ff))

endmodule

[sv/cdta_alert_unit.sv]
module cdta_alert_unit #(
   parameter int ALERT_CNT = 4
) (
   input  logic                                                   clock,
   input  logic                                                   reset,
   input  logic                                                   reload,
   input  logic                                                   advance,
   input  cdta_pkg::pipe_item_type                                item,
   input  logic [cdta_pkg::ALERT_REGS-1:0][cdta_pkg::ALERT_W-1:0] thresholds,
   output cdta_pkg::alert_result_type                             result
);
   import cdta_pkg::*;

   logic signed [SEC_W-1:0] last_ff, last_in;
   logic [ALERT_CNT-1:0]    done_ff, done_in;
   logic [REM_W:0]          rounded;
   logic [PROD_W-1:0]       prod;
   logic signed [SEC_W-1:0] sec;
   logic signed [SEC_W-1:0] sync_sec;
   logic signed [SEC_W-1:0] thr [ALERT_CNT];
   logic [MASK_W-1:0]       mask;

   // ceiling seconds of the remaining time
   assign rounded  = {1'b0, item.remaining} + ROUND_UP_MS;
   assign prod     = PROD_W'(rounded) * PROD_W'(SEC_RECIP);
   assign sec      = $signed(prod[SEC_SHIFT +: SEC_W]);
   assign sync_sec = $signed({1'b0, item.secs});

   always_comb begin
      for (int i = 0; i < ALERT_CNT; i++) begin
         thr[i] = $signed({{(SEC_W-ALERT_W){1'b0}}, thresholds[i]});
      end
   end

   always_comb begin
      last_in = last_ff;
      done_in = done_ff;
      mask    = '0;
      case (item.kind)
         OP_TICK: begin
            if (item.do_alert && (last_ff != sec)) begin
               for (int i = 0; i < ALERT_CNT; i++) begin
                  if (!done_ff[i] && (last_ff > thr[i]) && (sec <= thr[i])) begin
                     done_in[i] = 1'b1;
                     mask[i]    = 1'b1;
                  end
               end
               last_in = sec;
            end
         end
         OP_RESET: begin
            last_in = NO_SECONDS;
            done_in = '0;
         end
         OP_SYNC: begin
            last_in = sync_sec;
            for (int i = 0; i < ALERT_CNT; i++) begin
               done_in[i] = (thr[i] >= sync_sec);
            end
         end
         default: begin
         end
      endcase
   end

   assign result.mask    = mask;
   assign result.seconds = last_in;

   always_ff @(posedge clock) begin
      if (reset || reload) begin
         last_ff <= NO_SECONDS;
         done_ff <= '0;
      end else if (advance) begin
         last_ff <= last_in;
         done_ff <= done_in;
      end
   end

endmodule

[verif/countdown_timer_with_alerts_test.sv]
module countdown_timer_with_alerts_test;
   timeunit 1ns;
   timeprecision 1ps;

   import cdta_pkg::*;

   // Alert count the instance is built with; the predictor uses the same clamp.
   localparam int ALERTS_IN_USE = 4;
   localparam int ALERT_SLOTS   = (ALERTS_IN_USE < 4) ? ALERTS_IN_USE : 4;
   localparam int MS_IN_SECOND  = 1000;
   localparam int CEIL_PAD_MS   = 999;
   localparam int CYCLE_LIMIT   = 300000;
   localparam int HOLD_CYCLES   = 400;
   localparam int PRINT_CAP     = 100;
   // register index with nothing behind it; writes there must be dropped
   localparam logic [2:0] REG_UNUSED = 3'd5;

   typedef struct {
      op_type             op;
      logic [31:0]        stamp_ms;
      logic signed [16:0] sync_sec;
   } timer_event_type;

   typedef struct {
      logic [3:0]         mask;
      logic [25:0]        remaining;
      logic signed [16:0] seconds;
      logic               running;
      logic               started;
   } timer_result_type;

   // ---------------------------------------------------------------- DUT pins
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_op = '0;
   logic [31:0]        req_now_ms = '0;
   logic signed [16:0] req_sync_seconds = '0;

   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [3:0]         rsp_alert_mask;
   logic [25:0]        rsp_remaining_ms;
   logic signed [16:0] rsp_alert_seconds;
   logic               rsp_is_running;
   logic               rsp_was_started;

   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [4:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   countdown_timer_with_alerts #(
      .NUM_ALERTS(ALERTS_IN_USE)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_op(req_op),
      .req_now_ms(req_now_ms),
      .req_sync_seconds(req_sync_seconds),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_alert_mask(rsp_alert_mask),
      .rsp_remaining_ms(rsp_remaining_ms),
      .rsp_alert_seconds(rsp_alert_seconds),
      .rsp_is_running(rsp_is_running),
      .rsp_was_started(rsp_was_started),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   // ---------------------------------------------------------- timer predictor
   // Own copy of the register file and countdown state.
   logic [15:0] cd_total_sec;
   logic [9:0]  cd_threshold [4];
   logic [25:0] cd_remaining;
   logic [31:0] cd_last_tick;
   int          cd_last_alert;
   bit          cd_fired [4];
   bit          cd_running;
   bit          cd_started;

   // begin: reload total, stop, forget alerts
   function automatic void countdown_reload();
      cd_remaining  = 26'(int'(cd_total_sec) * MS_IN_SECOND);
      cd_running    = 1'b0;
      cd_started    = 1'b0;
      cd_last_tick  = '0;
      cd_last_alert = -1;
      for (int i = 0; i < 4; i++) cd_fired[i] = 1'b0;
   endfunction

   function automatic void countdown_power_on();
      cd_total_sec    = 16'd600;
      cd_threshold[0] = 10'd30;
      cd_threshold[1] = 10'd20;
      cd_threshold[2] = 10'd10;
      cd_threshold[3] = 10'd3;
      countdown_reload();
   endfunction

   function automatic void countdown_write_reg(logic [2:0] index, logic [31:0] data);
      if (index == REG_TOTAL) begin
         cd_total_sec = data[15:0];
         countdown_reload();
      end else if (index >= REG_ALERT0 && index <= REG_ALERT3) begin
         cd_threshold[2'(index - REG_ALERT0)] = data[9:0];
      end
   endfunction

   function automatic int ceil_seconds(logic [25:0] ms);
      return (int'(ms) + CEIL_PAD_MS) / MS_IN_SECOND;
   endfunction

   // Applies one event to the predictor state and returns the status it reports.
   function automatic timer_result_type countdown_apply(timer_event_type ev);
      timer_result_type r;
      logic [31:0]      elapsed;
      int               sec;
      int               whole;
      r.mask = '0;
      case (ev.op)
         OP_TICK: begin
            if (cd_running) begin
               elapsed      = ev.stamp_ms - cd_last_tick;  // modulo 2^32
               cd_last_tick = ev.stamp_ms;
               if (elapsed >= {6'b0, cd_remaining}) cd_remaining = '0;
               else cd_remaining = cd_remaining - elapsed[25:0];
               sec = ceil_seconds(cd_remaining);
               // alerts only look at a change of the whole-second count
               if (cd_last_alert != sec) begin
                  for (int i = 0; i < ALERT_SLOTS; i++) begin
                     if (!cd_fired[i] && cd_last_alert > int'(cd_threshold[i]) &&
                         sec <= int'(cd_threshold[i])) begin
                        cd_fired[i] = 1'b1;
                        r.mask[i]   = 1'b1;
                     end
                  end
                  cd_last_alert = sec;
               end
               if (cd_remaining == '0) cd_running = 1'b0;
            end
         end
         OP_START: begin
            if (!cd_running) begin
               cd_running   = 1'b1;
               cd_started   = 1'b1;
               cd_last_tick = ev.stamp_ms;
            end
         end
         OP_RESET: countdown_reload();
         default: begin
            // sync: negative targets clamp to zero
            whole         = ev.sync_sec[16] ? 0 : int'(ev.sync_sec[15:0]);
            cd_remaining  = 26'(whole * MS_IN_SECOND);
            cd_last_tick  = ev.stamp_ms;
            cd_last_alert = whole;
            for (int i = 0; i < ALERT_SLOTS; i++)
               cd_fired[i] = (int'(cd_threshold[i]) >= whole);
            if (cd_remaining == '0) cd_running = 1'b0;
         end
      endcase
      r.remaining = cd_remaining;
      r.seconds   = 17'(cd_last_alert);
      r.running   = cd_running;
      r.started   = cd_started;
      return r;
   endfunction

   // ------------------------------------------------------------ bookkeeping
   timer_event_type  pending_events [$];
   timer_result_type expected_status [$];
   timer_event_type  in_flight;
   int               issued_count = 0;
   int               accepted_count = 0;
   int               error_count = 0;
   int               cycle_count = 0;
   int               req_idle_pct = 0;
   int               rsp_idle_pct = 0;
   bit               hold_wanted = 1'b0;
   bit               hold_taken = 1'b0;
   int               hold_left = 0;
   logic [31:0]      clock_ms = '0;

   initial begin
      forever #2 clock = ~clock;
   end

   // run-away guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Event driver: a transfer happens on an edge with valid high and stall low.
   // The predictor runs on the accepted event at that edge.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_status.push_back(countdown_apply(in_flight));
            accepted_count++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_events.size() > 0 && $urandom_range(0, 99) >= req_idle_pct) begin
               in_flight = pending_events.pop_front();
               req_valid        <= 1'b1;
               req_op           <= in_flight.op;
               req_now_ms       <= in_flight.stamp_ms;
               req_sync_seconds <= in_flight.sync_sec;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result-side stall: random back-pressure, plus one long hold-off that
   // lets the pipeline fill and push back on the event channel.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_wanted && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
         end
      end
   end

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      if (error_count < PRINT_CAP)
         $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
      error_count++;
   endtask

   task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
      if (got !== want) report_mismatch(what, got, want);
   endtask

   // Result monitor: every result transfer is matched against the oldest prediction.
   always @(posedge clock) begin
      timer_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_status.size() == 0) begin
            report_mismatch("unexpected result transfer", 64'(rsp_remaining_ms), '0);
         end else begin
            want = expected_status.pop_front();
            check_field("alert_mask", rsp_alert_mask, want.mask);
            check_field("remaining_ms", rsp_remaining_ms, want.remaining);
            check_field("alert_seconds", rsp_alert_seconds, want.seconds);
            check_field("is_running", rsp_is_running, want.running);
            check_field("was_started", rsp_was_started, want.started);
         end
      end
   end

   // -------------------------------------------------------------- stimulus
   task automatic queue_event(op_type op, logic [31:0] stamp, logic signed [16:0] sync);
      timer_event_type ev;
      ev.op       = op;
      ev.stamp_ms = stamp;
      ev.sync_sec = sync;
      pending_events.push_back(ev);
      issued_count++;
   endtask

   // Wait until every queued event has gone through and its result came back,
   // then let the two-stage pipeline settle.
   task automatic wait_drained();
      while (accepted_count != issued_count || expected_status.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // APB write: setup cycle, then access until pready.
   task automatic csr_write(logic [2:0] index, logic [31:0] data);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      countdown_write_reg(index, data);
   endtask

   // Program thresholds and total; junk above each field width must be ignored.
   task automatic program_timer(int total, int a0, int a1, int a2, int a3);
      csr_write(REG_ALERT0, {22'($urandom_range(0, 4194303)), 10'(a0)});
      csr_write(REG_ALERT1, {22'($urandom_range(0, 4194303)), 10'(a1)});
      csr_write(REG_ALERT2, {22'($urandom_range(0, 4194303)), 10'(a2)});
      csr_write(REG_ALERT3, {22'($urandom_range(0, 4194303)), 10'(a3)});
      csr_write(REG_TOTAL, {16'($urandom), 16'(total)});
      csr_write(REG_UNUSED, $urandom);
   endtask

   function automatic logic signed [16:0] pick_sync_target();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 5)
         return 17'(int'(cd_threshold[$urandom_range(0, 3)]) + $urandom_range(0, 4));
      else if (sel < 7) return 17'($urandom_range(0, 60));
      else if (sel < 9) return 17'($urandom);
      else return 17'(-$urandom_range(1, 65536));
   endfunction

   // Mostly start / steady ticks so countdowns run through the alert zone;
   // syncs land near thresholds; some resets, clock jumps and junk.
   task automatic queue_random_events(int count);
      int          pick;
      int          sel;
      logic [31:0] step_ms;
      op_type      op;
      logic signed [16:0] sync;
      for (int n = 0; n < count; n++) begin
         pick    = $urandom_range(0, 99);
         sync    = 17'($urandom);
         step_ms = 32'($urandom_range(0, 50));
         if (pick < 3) begin
            op = OP_RESET;
         end else if (pick < 10) begin
            op = OP_START;
         end else if (pick < 17) begin
            op   = OP_SYNC;
            sync = pick_sync_target();
         end else if (pick < 21) begin
            op      = OP_TICK;
            step_ms = $urandom;  // arbitrary jump, wraps
         end else begin
            op  = OP_TICK;
            sel = $urandom_range(0, 9);
            if (sel < 6) step_ms = 32'($urandom_range(0, 2500));
            else if (sel < 9) step_ms = 32'($urandom_range(0, 200));
            else step_ms = 32'($urandom_range(0, 100000));
         end
         clock_ms = clock_ms + step_ms;
         queue_event(op, clock_ms, sync);
      end
   endtask

   int hi_total;

   initial begin
      countdown_power_on();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // sender idles now and then, receiver stalls about half the time
      req_idle_pct = 16;
      rsp_idle_pct = 52;

      // Directed walk through the corner cases with reset register values.
      queue_event(OP_TICK, 32'hFFFF_FFFF, 17'sh0FFFF);      // tick while stopped
      queue_event(OP_START, 32'hFFFF_F000, 17'sh1FFFF);
      queue_event(OP_START, 32'h0000_0005, 17'sh00000);     // start while running
      queue_event(OP_TICK, 32'h0000_0100, 17'sh15555);      // elapsed across wrap
      queue_event(OP_SYNC, 32'h0000_0200, 17'sd31);         // all alerts armed
      queue_event(OP_TICK, 32'h0000_0200 + 1500, 17'sh0AAAA);   // first alert
      queue_event(OP_TICK, 32'h0000_0200 + 16500, 17'sh00000);  // second alert
      queue_event(OP_TICK, 32'h0000_0200 + 28500, 17'sh00000);  // two at once
      queue_event(OP_TICK, 32'h0000_0200 + 40000, 17'sh00000);  // runs out, stops
      queue_event(OP_TICK, 32'h0000_0200 + 41000, 17'sh00000);  // stopped
      queue_event(OP_START, 32'h0001_0000, 17'sh00000);     // start with zero time
      queue_event(OP_TICK, 32'h0001_0000, 17'sh00000);      // next tick stops it
      queue_event(OP_SYNC, 32'h0001_0010, 17'sh10000);      // most negative, clamps
      queue_event(OP_SYNC, 32'h0001_0020, 17'sd65535);      // sync while stopped
      queue_event(OP_START, 32'h0000_0000, 17'sh00000);
      queue_event(OP_SYNC, 32'd1000, 17'sd25);              // sync while running
      queue_event(OP_TICK, 32'd6000, 17'sh00000);           // alert re-based by sync
      queue_event(OP_TICK, 32'hFFFF_FFFF, 17'sh00000);      // huge elapsed saturates
      queue_event(OP_RESET, 32'h1234_5678, 17'sh0F0F0);
      queue_event(OP_SYNC, 32'd50, -17'sd1);                // minus one clamps
      queue_event(OP_SYNC, 32'd60, 17'sd20);                // retires upper alerts
      queue_event(OP_START, 32'd100, 17'sh00000);
      queue_event(OP_TICK, 32'd100 + 10500, 17'sh00000);    // third alert fires
      queue_event(OP_RESET, 32'd0, 17'sh00000);
      wait_drained();

      // Random phases, each with its own register setting; idle pattern
      // moves from sender-light to receiver-light to none.
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: program_timer(40, 30, 20, 10, 3);
            1: program_timer(0, 0, 0, 1023, 1023);
            2: program_timer(65535, 1023, 700, 1, 0);
            default: begin
               hi_total = $urandom_range(1, 120);
               program_timer(hi_total, $urandom_range(0, hi_total + 5),
                             $urandom_range(0, hi_total + 5),
                             $urandom_range(0, hi_total + 5), $urandom_range(0, 1023));
            end
         endcase
         if (phase < 2) begin
            req_idle_pct = 16;
            rsp_idle_pct = 52;
         end else if (phase < 4) begin
            req_idle_pct = 52;
            rsp_idle_pct = 16;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         queue_random_events(320);
         // long receiver hold-off while the sender keeps pushing
         if (phase == 5) hold_wanted = 1'b1;
         wait_drained();
      end

      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
